>>> src/crsf_pkg.sv
// Shared types and constants of the CRSF frame parser.
package crsf_pkg;

   localparam logic [7:0] SYNC_BYTE = 8'hC8;
   localparam logic [7:0] TYPE_RC   = 8'h16;
   localparam logic [7:0] TYPE_LINK = 8'h14;
   localparam logic [7:0] CRC_POLY  = 8'hD5;

   localparam int CHANNEL_BITS     = 11;
   localparam int RC_PAYLOAD_BYTES = 22;
   localparam int STORE_ADDR_BITS  = 5;
   localparam int ACC_BITS         = CHANNEL_BITS + 7;
   localparam int ACC_CNT_BITS     = 5;

   localparam logic [7:0] MIN_LENGTH  = 8'd2;
   localparam logic [7:0] LEN_CEILING = 8'd62;
   localparam logic [STORE_ADDR_BITS-1:0] LQ_BYTE = STORE_ADDR_BITS'(2);

   localparam logic [15:0] TIMEOUT_RESET    = 16'd100;
   localparam logic [5:0]  MAX_LENGTH_RESET = 6'd60;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT_MS = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_LENGTH = 1'd1;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [1:0] KIND_CHANNEL = 2'd0;
   localparam logic [1:0] KIND_LINK    = 2'd1;
   localparam logic [1:0] KIND_LOST    = 2'd2;

   typedef struct packed {
      logic clear;
      logic start;
   } crc_ctl_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

endpackage

>>> src/crsf_crc.sv
// Bit-serial CRC-8 unit with polynomial 0xD5, one shift per cycle.
module crsf_crc
   import crsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  crc_ctl_type ctl,
   input  logic [7:0]  data_in,
   output logic        busy,
   output logic [7:0]  crc
);

   logic [7:0] crc_ff, crc_in;
   logic [2:0] bit_cnt_ff, bit_cnt_in;
   logic       busy_ff, busy_in;

   always_comb begin
      crc_in     = crc_ff;
      bit_cnt_in = bit_cnt_ff;
      busy_in    = busy_ff;
      if (ctl.clear) begin
         crc_in = '0;
      end else if (ctl.start) begin
         crc_in     = crc_ff ^ data_in;
         bit_cnt_in = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         crc_in     = crc_ff[7] ? ({crc_ff[6:0], 1'b0} ^ CRC_POLY) : {crc_ff[6:0], 1'b0};
         bit_cnt_in = bit_cnt_ff + 3'd1;
         if (bit_cnt_ff == 3'd7) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff     <= '0;
         bit_cnt_ff <= '0;
         busy_ff    <= 1'b0;
      end else begin
         crc_ff     <= crc_in;
         bit_cnt_ff <= bit_cnt_in;
         busy_ff    <= busy_in;
      end
   end

   assign busy = busy_ff;
   assign crc  = crc_ff;

endmodule

>>> src/crsf_store.sv
// Payload byte store with per-entry valid bits and a registered read port.
module crsf_store
   import crsf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  store_ctl_type              ctl,
   input  logic [STORE_ADDR_BITS-1:0] wr_addr,
   input  logic [7:0]                 wr_data,
   input  logic [STORE_ADDR_BITS-1:0] rd_addr,
   output logic [7:0]                 rd_data
);

   logic [7:0]                  mem [RC_PAYLOAD_BYTES];
   logic [RC_PAYLOAD_BYTES-1:0] valid_ff;
   logic [7:0]                  rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : 8'd0;
      end
   end

   // Entries never written read as zero, matching the cleared store.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/crsf_frame_parser.sv
// Top level of the CRSF frame parser: sequencer, link timer and result register.
// A frame byte that enters the CRC is accepted and the block then stalls while the
// bit-serial CRC unit shifts; other bytes and ticks stall it only through the states they start.
// A link-lost or link-quality result is registered from the S_LOST or S_LQ state that its
// transaction enters; it waits there only while a stalled result holds the result register.
// A good RC frame unpacks its channels through the single store read port, alternating
// between S_FETCH, which adds a store byte to the accumulator, and S_RC, which emits a channel.
// Synchronous active-high reset clears control state and all store valid bits at once.
module crsf_frame_parser
   import crsf_pkg::*;
#(
   parameter int NUM_CHANNELS = 16
)
(
   input  logic                      clock,
   input  logic                      reset,
   // Input channel.
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_cmd,
   input  logic [7:0]                req_rx_byte,
   // Result channel.
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_kind,
   output logic [3:0]                rsp_channel_index,
   output logic [10:0]               rsp_channel_value,
   output logic [7:0]                rsp_link_quality,
   output logic                      rsp_link_active,
   output logic                      rsp_last,
   // Configuration port.
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data
);

   localparam logic [3:0] LAST_CHAN = 4'(NUM_CHANNELS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOST,
      S_LQ,
      S_RC,
      S_FETCH
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [15:0] timeout_ff;
   logic [5:0]  max_length_ff;

   // Frame tracking and link state.
   logic [5:0]  pos_ff, pos_in;
   logic [5:0]  len_ff, len_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] ms_ff, ms_in;
   logic        link_up_ff, link_up_in;

   // Channel unpacking: a little-endian bit accumulator fed one store byte at a time.
   logic [ACC_BITS-1:0]        acc_ff, acc_in;
   logic [ACC_CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [STORE_ADDR_BITS-1:0] addr_ff, addr_in;
   logic [3:0]                 chan_ff, chan_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [3:0]  index_ff, index_in;
   logic [10:0] value_ff, value_in;
   logic [7:0]  lq_ff, lq_in;
   logic        active_ff, active_in;
   logic        last_ff, last_in;

   // Shared units.
   crc_ctl_type                crc_ctl;
   logic                       crc_busy;
   logic [7:0]                 crc_value;
   store_ctl_type              store_ctl;
   logic [STORE_ADDR_BITS-1:0] store_wr_addr;
   logic [STORE_ADDR_BITS-1:0] store_rd_addr;
   logic [7:0]                 store_rd_data;

   logic        req_accept;
   logic        out_free;
   logic [15:0] ms_inc;
   logic [5:0]  pos_m3;

   crsf_crc u_crc (
      .clock   (clock),
      .reset   (reset),
      .ctl     (crc_ctl),
      .data_in (req_rx_byte),
      .busy    (crc_busy),
      .crc     (crc_value)
   );

   crsf_store u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (store_ctl),
      .wr_addr (store_wr_addr),
      .wr_data (req_rx_byte),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   // A new transaction is taken only in idle and once the CRC unit has finished the
   // previous byte, so the final byte of a frame always sees a settled CRC.
   assign req_stall  = (state_ff != S_IDLE) || crc_busy;
   assign req_accept = req_valid && !req_stall;

   // The result register can take a new result when empty or when its current
   // transaction completes in this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign ms_inc = (ms_ff == 16'hFFFF) ? ms_ff : ms_ff + 16'd1;
   assign pos_m3 = pos_ff - 6'd3;

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      len_in        = len_ff;
      type_in       = type_ff;
      ms_in         = ms_ff;
      link_up_in    = link_up_ff;
      acc_in        = acc_ff;
      cnt_in        = cnt_ff;
      addr_in       = addr_ff;
      chan_in       = chan_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      kind_in       = kind_ff;
      index_in      = index_ff;
      value_in      = value_ff;
      lq_in         = lq_ff;
      active_in     = active_ff;
      last_in       = last_ff;
      crc_ctl       = '0;
      store_ctl     = '0;
      store_wr_addr = pos_m3[STORE_ADDR_BITS-1:0];
      store_rd_addr = addr_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_cmd == CMD_TICK) begin
                  ms_in = ms_inc;
                  if (link_up_ff && (ms_inc > timeout_ff)) begin
                     link_up_in = 1'b0;
                     state_in   = S_LOST;
                  end
               end else if (pos_ff == 6'd0) begin
                  if (req_rx_byte == SYNC_BYTE) begin
                     pos_in = 6'd1;
                  end
               end else if (pos_ff == 6'd1) begin
                  // A bad length byte drops back to hunting and is not a sync candidate.
                  if ((req_rx_byte < MIN_LENGTH) || (req_rx_byte > {2'b00, max_length_ff})
                      || (req_rx_byte > LEN_CEILING)) begin
                     pos_in = 6'd0;
                  end else begin
                     len_in        = req_rx_byte[5:0];
                     crc_ctl.clear = 1'b1;
                     pos_in        = 6'd2;
                  end
               end else if (({1'b0, pos_ff} - 7'd1) < {1'b0, len_ff}) begin
                  // Type or payload byte; payload beyond the store only enters the CRC.
                  if (pos_ff == 6'd2) begin
                     type_in = req_rx_byte;
                  end else if (pos_m3 < 6'(RC_PAYLOAD_BYTES)) begin
                     store_ctl.wr_en = 1'b1;
                  end
                  crc_ctl.start = 1'b1;
                  pos_in        = pos_ff + 6'd1;
               end else begin
                  // CRC byte closes the frame whatever the outcome.
                  pos_in = 6'd0;
                  if (crc_value == req_rx_byte) begin
                     if (type_ff == TYPE_RC) begin
                        link_up_in = 1'b1;
                        ms_in      = '0;
                        acc_in     = '0;
                        cnt_in     = '0;
                        addr_in    = '0;
                        chan_in    = '0;
                        state_in   = S_RC;
                     end else if (type_ff == TYPE_LINK) begin
                        store_ctl.rd_en = 1'b1;
                        store_rd_addr   = LQ_BYTE;
                        state_in        = S_LQ;
                     end
                  end
               end
            end
         end
         S_LOST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_LOST;
               index_in     = '0;
               value_in     = '0;
               lq_in        = '0;
               active_in    = link_up_ff;
               last_in      = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_LQ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_LINK;
               index_in     = '0;
               value_in     = '0;
               lq_in        = store_rd_data;
               active_in    = link_up_ff;
               last_in      = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_RC: begin
            if (cnt_ff >= ACC_CNT_BITS'(CHANNEL_BITS)) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_CHANNEL;
                  index_in     = chan_ff;
                  value_in     = acc_ff[CHANNEL_BITS-1:0];
                  lq_in        = '0;
                  active_in    = link_up_ff;
                  last_in      = (chan_ff == LAST_CHAN);
                  acc_in       = acc_ff >> CHANNEL_BITS;
                  cnt_in       = cnt_ff - ACC_CNT_BITS'(CHANNEL_BITS);
                  chan_in      = chan_ff + 4'd1;
                  if (chan_ff == LAST_CHAN) begin
                     state_in = S_IDLE;
                  end
               end
            end else begin
               store_ctl.rd_en = 1'b1;
               state_in        = S_FETCH;
            end
         end
         S_FETCH: begin
            acc_in   = acc_ff | (ACC_BITS'(store_rd_data) << cnt_ff);
            cnt_in   = cnt_ff + ACC_CNT_BITS'(8);
            addr_in  = addr_ff + STORE_ADDR_BITS'(1);
            state_in = S_RC;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         len_ff       <= '0;
         type_ff      <= '0;
         ms_ff        <= '0;
         link_up_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         type_ff      <= type_in;
         ms_ff        <= ms_in;
         link_up_ff   <= link_up_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff    <= acc_in;
      cnt_ff    <= cnt_in;
      addr_ff   <= addr_in;
      chan_ff   <= chan_in;
      kind_ff   <= kind_in;
      index_ff  <= index_in;
      value_ff  <= value_in;
      lq_ff     <= lq_in;
      active_ff <= active_in;
      last_ff   <= last_in;
   end

   // Configuration registers take a write in any cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TIMEOUT_RESET;
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TIMEOUT_MS: timeout_ff    <= csr_wr_data[15:0];
            CSR_MAX_LENGTH: max_length_ff <= csr_wr_data[5:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_channel_index = index_ff;
   assign rsp_channel_value = value_ff;
   assign rsp_link_quality  = lq_ff;
   assign rsp_link_active   = active_ff;
   assign rsp_last          = last_ff;

`ifndef SYNTHESIS
   // The final channel of an RC frame is the one that closes the run.
   a_last_channel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_CHANNEL && rsp_last) |-> rsp_channel_index == LAST_CHAN)
      else $error("last channel result carries the wrong index");

   // Channel results only follow a good RC frame, which raises the link.
   a_channel_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_CHANNEL) |-> rsp_link_active)
      else $error("channel result with link inactive");

   // A link-lost result reports the link already dropped.
   a_lost_inactive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_LOST) |-> !rsp_link_active && rsp_last)
      else $error("link lost result with link still active");

   // The CRC unit is never restarted while it is still shifting a byte.
   a_crc_no_overlap: assert property (@(posedge clock) disable iff (reset)
      crc_busy |-> !crc_ctl.start && !crc_ctl.clear)
      else $error("CRC unit started while busy");
`endif

endmodule

>>> test/crsf_frame_parser_test.sv
// Self-checking testbench for the CRSF frame parser: directed and random byte and tick traffic.
module crsf_frame_parser_test import crsf_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_CHANNELS  = 16;
   // During the channel unpack of a good RC frame the input is stalled, and a stalled
   // receiver holds results back. This bound is many times the worst quiet stretch.
   localparam int QUIET_LIMIT   = 4000;
   // A frame byte busies the block while the CRC unit shifts, and an unpack until its last result,
   // so this long after the last expected result the block is surely idle.
   localparam int SETTLE_CYCLES = 100;
   localparam int RANDOM_QUOTA  = 10;
   localparam int RANDOM_FILL   = -1;
   // A frame type that the parser neither decodes nor reports.
   localparam logic [7:0] TYPE_OTHER = 8'h29;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  chan;
      logic [10:0] value;
      logic [7:0]  quality;
      logic        active;
      logic        is_last;
   } rc_result_type;

   typedef logic [7:0] octet_q_type[$];

   // Tracks the parser and link state from every accepted transaction and holds the
   // results that the block owes, oldest first.
   class rc_link_tracker;
      logic [15:0]   timeout_ms;
      logic [5:0]    max_length;
      int unsigned   position;
      logic [5:0]    frame_len;
      logic [7:0]    crc;
      logic [7:0]    frame_type;
      logic [7:0]    store[RC_PAYLOAD_BYTES];
      logic [15:0]   ms_count;
      logic          link_up;
      rc_result_type awaited[$];
      int            errors;

      function new();
         timeout_ms = TIMEOUT_RESET;
         max_length = MAX_LENGTH_RESET;
         position   = 0;
         frame_len  = '0;
         crc        = '0;
         frame_type = '0;
         foreach (store[i]) store[i] = '0;
         ms_count   = '0;
         link_up    = 1'b0;
         errors     = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_BITS-1:0] idx,
                                 logic [CSR_DATA_BITS-1:0] value);
         if (idx == CSR_TIMEOUT_MS)
            timeout_ms = value[15:0];
         else if (idx == CSR_MAX_LENGTH)
            max_length = value[5:0];
      endfunction

      function logic [7:0] crc8_step(logic [7:0] acc, logic [7:0] data);
         logic [7:0] r;
         r = acc ^ data;
         for (int i = 0; i < 8; i++)
            r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
         return r;
      endfunction

      // Bytes past the end of the store read as zero.
      function logic [7:0] stored(int unsigned i);
         return (i < RC_PAYLOAD_BYTES) ? store[i] : 8'h00;
      endfunction

      function logic [10:0] channel_of(int unsigned c);
         int unsigned bitpos;
         logic [23:0] window;
         bitpos = c * CHANNEL_BITS;
         window = {stored(bitpos / 8 + 2), stored(bitpos / 8 + 1), stored(bitpos / 8)};
         return 11'(window >> (bitpos % 8));
      endfunction

      function void queue_result(logic [1:0] kind, logic [3:0] chan, logic [10:0] value,
                                 logic [7:0] quality, logic is_last);
         awaited.push_back('{kind, chan, value, quality, link_up, is_last});
      endfunction

      function void absorb_input(logic cmd, logic [7:0] data);
         int unsigned slot;
         if (cmd == CMD_TICK) begin
            if (ms_count != 16'hFFFF)
               ms_count++;
            if (link_up && ms_count > timeout_ms) begin
               link_up = 1'b0;
               queue_result(KIND_LOST, '0, '0, '0, 1'b1);
            end
            return;
         end
         if (position == 0) begin
            if (data == SYNC_BYTE)
               position = 1;
            return;
         end
         if (position == 1) begin
            if (data < MIN_LENGTH || data > max_length || data > LEN_CEILING) begin
               position = 0;
            end else begin
               frame_len = data[5:0];
               crc       = '0;
               position  = 2;
            end
            return;
         end
         slot = position - 2;
         if (slot + 1 < frame_len) begin
            if (slot == 0)
               frame_type = data;
            else if (slot - 1 < RC_PAYLOAD_BYTES)
               store[slot - 1] = data;
            crc      = crc8_step(crc, data);
            position = position + 1;
            return;
         end
         position = 0;
         if (crc != data)
            return;
         if (frame_type == TYPE_RC) begin
            link_up  = 1'b1;
            ms_count = '0;
            for (int c = 0; c < NUM_CHANNELS; c++)
               queue_result(KIND_CHANNEL, 4'(c), channel_of(c), '0, c == NUM_CHANNELS - 1);
         end else if (frame_type == TYPE_LINK) begin
            queue_result(KIND_LINK, '0, '0, stored(LQ_BYTE), 1'b1);
         end
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void match_result(logic [1:0] kind, logic [3:0] chan, logic [10:0] value,
                                 logic [7:0] quality, logic active, logic is_last);
         rc_result_type want;
         if (awaited.size() == 0) begin
            $error("result with nothing outstanding: kind %0d, channel_index %0d",
                   kind, chan);
            errors++;
            return;
         end
         want = awaited.pop_front();
         compare_field("kind", want.kind, kind);
         compare_field("channel_index", want.chan, chan);
         compare_field("channel_value", want.value, value);
         compare_field("link_quality", want.quality, quality);
         compare_field("link_active", want.active, active);
         compare_field("last", want.is_last, is_last);
      endfunction
   endclass

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   logic                      req_cmd     = 1'b0;
   logic [7:0]                req_rx_byte = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   logic [1:0]                rsp_kind;
   logic [3:0]                rsp_channel_index;
   logic [10:0]               rsp_channel_value;
   logic [7:0]                rsp_link_quality;
   logic                      rsp_link_active;
   logic                      rsp_last;
   logic                      csr_wr_en   = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wr_data = '0;

   rc_link_tracker tracker;
   // Percent chance per cycle that the sender holds back or the receiver stalls.
   int send_idle_pct = 0;
   int stall_pct     = 0;
   // Transactions that the block acts on; bytes it skips while hunting for sync do not count.
   int useful_items  = 0;
   int quiet_cycles  = 0;
   int idle_plan[4]  = '{0, 57, 0, 30};
   int stall_plan[4] = '{0, 0, 57, 30};

   crsf_frame_parser #(.NUM_CHANNELS(NUM_CHANNELS)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_link_quality  (rsp_link_quality),
      .rsp_link_active   (rsp_link_active),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The receiver decides at each falling edge whether to stall the next rising edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Every result transaction is checked against the oldest outstanding expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.match_result(rsp_kind, rsp_channel_index, rsp_channel_value,
                              rsp_link_quality, rsp_link_active, rsp_last);
   end

   // The run is declared hung once neither channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Offers one transaction from a falling edge and returns at the falling edge after it
   // was taken. Valid stays high on return so that back-to-back transactions need no drop.
   task automatic send_item(input logic cmd, input logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid   = 1'b0;
         req_cmd     = 1'($urandom_range(1));
         req_rx_byte = 8'($urandom_range(255));
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_cmd     = cmd;
      req_rx_byte = data;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (cmd == CMD_TICK || tracker.position != 0 || data == SYNC_BYTE)
         useful_items++;
      tracker.absorb_input(cmd, data);
      @(negedge clock);
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_item(CMD_TICK, 8'($urandom_range(255)));
   endtask

   // A frame byte, sometimes preceded by a tick so that time passes inside a frame.
   task automatic frame_byte(input logic [7:0] data, input int tick_pct);
      if ($urandom_range(99) < tick_pct)
         send_item(CMD_TICK, 8'($urandom_range(255)));
      send_item(CMD_BYTE, data);
   endtask

   task automatic send_frame(input logic [7:0] ftype, input octet_q_type body,
                             input bit good_crc, input int tick_pct);
      logic [7:0] check;
      check = tracker.crc8_step(8'h00, ftype);
      foreach (body[i]) check = tracker.crc8_step(check, body[i]);
      if (!good_crc)
         check = check ^ 8'($urandom_range(255, 1));
      frame_byte(SYNC_BYTE, tick_pct);
      frame_byte(8'(body.size() + MIN_LENGTH), tick_pct);
      frame_byte(ftype, tick_pct);
      foreach (body[i]) frame_byte(body[i], tick_pct);
      frame_byte(check, tick_pct);
   endtask

   function automatic octet_q_type make_body(input int count, input int fill);
      octet_q_type body;
      repeat (count) body.push_back((fill == RANDOM_FILL) ? 8'($urandom_range(255)) : 8'(fill));
      return body;
   endfunction

   // After noise or a broken frame the parser may sit inside a frame; random bytes finish
   // it off so that the next frame starts from sync hunt.
   task automatic resync();
      while (tracker.position != 0)
         send_item(CMD_BYTE, 8'($urandom_range(255)));
   endtask

   // Drops valid, waits for every owed result and lets the block go idle.
   task automatic settle();
      req_valid = 1'b0;
      while (tracker.awaited.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = value;
      tracker.set_register(idx, value);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Mostly well-formed frames with random content; the rest is tick bursts that may run long enough
   // to drop the link, stray bytes and frames cut short after the sync byte.
   task automatic random_traffic(input int quota);
      int start_count;
      int pick;
      int room;
      int len;
      start_count = useful_items;
      while (useful_items - start_count < quota) begin
         room = (tracker.max_length > LEN_CEILING) ? LEN_CEILING : tracker.max_length;
         room = (room > MIN_LENGTH) ? room - MIN_LENGTH : 0;
         pick = $urandom_range(99);
         if (pick < 50) begin
            len = (room >= RC_PAYLOAD_BYTES && $urandom_range(9) < 7) ? RC_PAYLOAD_BYTES
                                                                      : $urandom_range(room);
            send_frame(TYPE_RC, make_body(len, RANDOM_FILL), $urandom_range(99) < 85, 5);
         end else if (pick < 65) begin
            len = $urandom_range((room < 8) ? room : 8);
            send_frame(TYPE_LINK, make_body(len, RANDOM_FILL), $urandom_range(99) < 85, 5);
         end else if (pick < 72) begin
            send_frame(8'($urandom_range(255)), make_body($urandom_range(room), RANDOM_FILL),
                       $urandom_range(1) == 1, 5);
         end else if (pick < 85) begin
            send_ticks($urandom_range(int'(tracker.timeout_ms) + 4, 1));
         end else if (pick < 92) begin
            repeat ($urandom_range(4, 1)) send_item(CMD_BYTE, 8'($urandom_range(255)));
         end else begin
            send_item(CMD_BYTE, SYNC_BYTE);
            send_item(CMD_BYTE, 8'($urandom_range(255)));
            repeat ($urandom_range(5)) send_item(CMD_BYTE, 8'($urandom_range(255)));
         end
         resync();
      end
   endtask

   initial begin
      octet_q_type body;
      tracker = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset configuration: timeout of 100 ms, longest frame 60.
      // A link statistics frame is reported even while the link is down.
      body = {8'h00, 8'h00, 8'hFF};
      send_frame(TYPE_LINK, body, 1'b1, 0);
      // Length bytes below two, above the limit and above the hard ceiling all restart the
      // hunt. A sync value in the length slot is rejected and not taken as a new sync, so
      // the frame that follows it is skipped.
      send_item(CMD_BYTE, SYNC_BYTE);
      send_item(CMD_BYTE, 8'd0);
      send_item(CMD_BYTE, SYNC_BYTE);
      send_item(CMD_BYTE, 8'd1);
      send_item(CMD_BYTE, SYNC_BYTE);
      send_item(CMD_BYTE, 8'd63);
      send_item(CMD_BYTE, SYNC_BYTE);
      send_item(CMD_BYTE, 8'd61);
      send_item(CMD_BYTE, SYNC_BYTE);
      body = {8'h01, 8'h02, 8'h03};
      send_frame(TYPE_LINK, body, 1'b1, 0);
      resync();
      // All-ones channels, link quality while up, a corrupted CRC and an unknown type.
      send_frame(TYPE_RC, make_body(RC_PAYLOAD_BYTES, 8'hFF), 1'b1, 0);
      body = {8'hFF, 8'hFF, 8'h00};
      send_frame(TYPE_LINK, body, 1'b1, 0);
      send_frame(TYPE_RC, make_body(6, RANDOM_FILL), 1'b0, 0);
      send_frame(TYPE_OTHER, make_body(5, RANDOM_FILL), 1'b1, 0);
      // The link holds for exactly the timeout and is lost once on the tick after it.
      send_ticks(102);
      settle();

      // Shortest frames only, and a zero timeout that drops the link on the first tick.
      // Empty RC and link statistics frames decode whatever the store still holds.
      write_reg(CSR_TIMEOUT_MS, 16'd0);
      write_reg(CSR_MAX_LENGTH, 16'd2);
      send_frame(TYPE_RC, make_body(0, 0), 1'b1, 0);
      send_ticks(2);
      send_frame(TYPE_LINK, make_body(0, 0), 1'b1, 0);
      send_item(CMD_BYTE, SYNC_BYTE);
      send_item(CMD_BYTE, 8'd3);
      settle();

      // A limit of 63 behaves as 62; the longest frame carries bytes past the store.
      write_reg(CSR_TIMEOUT_MS, 16'd1);
      write_reg(CSR_MAX_LENGTH, 16'd63);
      send_frame(TYPE_RC, make_body(LEN_CEILING - MIN_LENGTH, RANDOM_FILL), 1'b1, 0);
      send_ticks(3);
      send_item(CMD_BYTE, SYNC_BYTE);
      send_item(CMD_BYTE, 8'd63);
      settle();

      // The largest timeout holds the link; lowering the timeout below the elapsed count
      // then drops it on the very next tick.
      write_reg(CSR_TIMEOUT_MS, 16'hFFFF);
      send_frame(TYPE_RC, make_body(0, 0), 1'b1, 0);
      send_ticks(6);
      settle();
      write_reg(CSR_TIMEOUT_MS, 16'd3);
      send_ticks(2);
      settle();

      // Random traffic under each idling pattern with a fresh configuration each time.
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_plan[phase];
         stall_pct     = stall_plan[phase];
         write_reg(CSR_TIMEOUT_MS, 16'($urandom_range(30, 3)));
         case (phase)
            0: begin
               write_reg(CSR_MAX_LENGTH, 16'(LEN_CEILING));
            end
            1: begin
               write_reg(CSR_MAX_LENGTH, 16'($urandom_range(62, 24)));
            end
            2: begin
               write_reg(CSR_MAX_LENGTH, 16'(MAX_LENGTH_RESET));
            end
            default: begin
               write_reg(CSR_MAX_LENGTH, 16'($urandom_range(62, 2)));
            end
         endcase
         random_traffic(RANDOM_QUOTA);
         settle();
      end

      if (tracker.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> sim.f
src/crsf_pkg.sv
src/crsf_crc.sv
src/crsf_store.sv
src/crsf_frame_parser.sv
test/crsf_frame_parser_test.sv
